### sv/hcbd_pkg.sv
// Package for the chunked body decoder: item structs, parser phase codes,
// result kinds, error codes and the hex digit decoder. No dependencies.
package hcbd_pkg;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       new_body;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
  } out_item_t;

  // parser phases
  localparam logic [2:0] PH_DIGITS  = 3'd0;
  localparam logic [2:0] PH_EXT     = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_DATA_CR = 3'd3;
  localparam logic [2:0] PH_DATA_LF = 3'd4;
  localparam logic [2:0] PH_TRAILER = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;
  localparam logic [2:0] PH_ERROR   = 3'd7;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_SIZE  = 3'd1;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd2;
  localparam logic [2:0] ERR_LINE_LONG = 3'd3;
  localparam logic [2:0] ERR_NO_CRLF   = 3'd4;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  localparam int          MAX_SIZE_W     = 31;
  localparam logic [30:0] MAX_SIZE_RESET = 31'h7FFF_FFFF;

  localparam logic [2:0] REG_MAX_CHUNK = 3'd0;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

### sv/http_chunked_body_decoder.sv
// Chunked transfer decoder top level: byte parser, result register and skid.
// Depends on hcbd_pkg.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   hcbd_pkg::in_item_t
//   out_     output     out_valid / out_stall hcbd_pkg::out_item_t
//   cfg      input      APB psel/penable      max_chunk_size at address 0
//
// One body byte per cycle while in_stall is low; each result is registered.
// The parser state update is the only loop; a result that meets a stalled
// output register goes to a one-entry skid, and in_stall is high while the
// skid holds a result. rst_n is synchronous; all parser state is cleared
// and max_chunk_size returns to 0x7FFFFFFF.
module http_chunked_body_decoder #(
  parameter int SIZE_LINE_MAX = 63,
  parameter int COUNT_WIDTH   = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hcbd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hcbd_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import hcbd_pkg::*;

  localparam int LW    = $clog2(SIZE_LINE_MAX);
  localparam int CMP_W = (COUNT_WIDTH > MAX_SIZE_W) ? COUNT_WIDTH : MAX_SIZE_W;

  logic [MAX_SIZE_W-1:0]  max_r;
  logic [2:0]             phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   dig_r, dig_nxt;
  logic                   crp_r, crp_nxt;
  logic [LW-1:0]          llen_r, llen_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic                   tle_r, tle_nxt;

  logic       out_v_r, skid_v_r;
  out_item_t  out_r, skid_r;

  logic       in_fire, pop;
  logic       res_v;
  out_item_t  res;
  logic [4:0] hx;
  logic [COUNT_WIDTH-1:0] rem_dec;

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_MAX_CHUNK[0]) ? {1'b0, max_r} : 32'd0;
  assign in_stall  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign in_fire   = in_valid && !skid_v_r;
  assign pop       = out_v_r && !out_stall;
  assign hx        = hex_decode(in_data.body_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_SIZE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_CHUNK[0]) begin
      max_r <= pwdata[MAX_SIZE_W-1:0];
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    dig_nxt   = dig_r;
    crp_nxt   = crp_r;
    llen_nxt  = llen_r;
    rem_nxt   = rem_r;
    tle_nxt   = tle_r;
    res_v     = 1'b0;
    res       = '{payload_byte: 8'd0, kind: KIND_PAYLOAD, error_code: ERR_NONE};
    rem_dec   = rem_r - COUNT_WIDTH'(1);

    if (in_data.new_body) begin
      phase_nxt = PH_DIGITS;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      dig_nxt   = 1'b0;
      crp_nxt   = 1'b0;
      llen_nxt  = '0;
      rem_nxt   = '0;
      tle_nxt   = 1'b1;
      rem_dec   = '1;
    end

    unique case (phase_nxt)
      PH_DIGITS, PH_EXT: begin
        if (in_data.body_byte == CH_LF) begin
          // end of size line: validate and pick data or trailer
          if (!dig_nxt) begin
            res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_BAD_SIZE;
            phase_nxt = PH_ERROR;
          end else if (ovf_nxt || CMP_W'(acc_nxt) > CMP_W'(max_r)) begin
            res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_TOO_LARGE;
            phase_nxt = PH_ERROR;
          end else if (acc_nxt == '0) begin
            phase_nxt = PH_TRAILER;
            tle_nxt   = 1'b1;
            crp_nxt   = 1'b0;
          end else begin
            rem_nxt   = acc_nxt;
            phase_nxt = PH_DATA;
          end
        end else if (llen_nxt >= LW'(SIZE_LINE_MAX - 1)) begin
          res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_LINE_LONG;
          phase_nxt = PH_ERROR;
        end else begin
          llen_nxt = llen_nxt + LW'(1);
          if (phase_nxt == PH_DIGITS) begin
            if (in_data.body_byte == CH_CR) begin
              if (crp_nxt) begin
                res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_BAD_SIZE;
                phase_nxt = PH_ERROR;
              end else begin
                crp_nxt = 1'b1;
              end
            end else if (crp_nxt) begin
              res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_BAD_SIZE;
              phase_nxt = PH_ERROR;
            end else if (in_data.body_byte == CH_SEMI) begin
              if (!dig_nxt) begin
                res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_BAD_SIZE;
                phase_nxt = PH_ERROR;
              end else begin
                phase_nxt = PH_EXT;
              end
            end else if (!hx[4]) begin
              res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_BAD_SIZE;
              phase_nxt = PH_ERROR;
            end else begin
              dig_nxt = 1'b1;
              // stick the overflow flag instead of shifting out nonzero digits
              if (acc_nxt[COUNT_WIDTH-1 -: 4] != 4'd0) begin
                ovf_nxt = 1'b1;
              end else begin
                acc_nxt = {acc_nxt[COUNT_WIDTH-5:0], hx[3:0]};
              end
            end
          end
        end
      end
      PH_DATA: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = PH_DATA_CR;
        end
        res_v = 1'b1;
        res.payload_byte = in_data.body_byte;
      end
      PH_DATA_CR: begin
        if (in_data.body_byte != CH_CR) begin
          res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_NO_CRLF;
          phase_nxt = PH_ERROR;
        end else begin
          phase_nxt = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (in_data.body_byte != CH_LF) begin
          res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_NO_CRLF;
          phase_nxt = PH_ERROR;
        end else begin
          phase_nxt = PH_DIGITS;
          acc_nxt   = '0;
          ovf_nxt   = 1'b0;
          dig_nxt   = 1'b0;
          crp_nxt   = 1'b0;
          llen_nxt  = '0;
        end
      end
      PH_TRAILER: begin
        if (in_data.body_byte == CH_LF) begin
          if (tle_nxt) begin
            phase_nxt = PH_DONE;
            res_v = 1'b1;
            res.kind = KIND_END;
          end else begin
            tle_nxt = 1'b1;
            crp_nxt = 1'b0;
          end
        end else if (in_data.body_byte == CH_CR && tle_nxt && !crp_nxt) begin
          crp_nxt = 1'b1;
        end else begin
          tle_nxt = 1'b0;
        end
      end
      default: begin
        // done or error: drop bytes until a new body
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DIGITS;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      dig_r   <= 1'b0;
      crp_r   <= 1'b0;
      llen_r  <= '0;
      rem_r   <= '0;
      tle_r   <= 1'b1;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      dig_r   <= dig_nxt;
      crp_r   <= crp_nxt;
      llen_r  <= llen_nxt;
      rem_r   <= rem_nxt;
      tle_r   <= tle_nxt;
    end
  end

  // Output register with a one-entry skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= in_fire && res_v;
      end
    end else if (in_fire && res_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (in_fire && res_v) begin
      skid_r <= res;
    end
  end

endmodule

### sv/hcbd_checker.sv
// Port-level checks for the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg and http_chunked_body_decoder.
module hcbd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input hcbd_pkg::out_item_t out_data
);
  import hcbd_pkg::*;

  // a held result keeps its value until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input back-pressure only follows a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("in_stall without a stalled result");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall survives reset");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind == KIND_ERROR) == (out_data.error_code != ERR_NONE))
    else $error("error code does not match result kind");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
